// File: rtl/ggc_pkg.sv
// Package for the gravity gradient correction block: payload structs,
// field widths and the saturation limits.
// Used by gravity_gradient_correction and the dv files; depends on nothing.
package ggc_pkg;

	// field widths
	localparam int POS_W = 40;
	localparam int ERR_W = 32;
	localparam int MU_W = 64;
	localparam int ACC_W = 64;

	// quotient bits kept by the divider and root bits of the square root
	localparam int QUO_W = 129;
	localparam int ROOT_W = (QUO_W + 1) / 2;
	// bits of |r|^10 that can be nonzero (|r|^2 <= 3 * 2^78)
	localparam int DEN_W = 400;
	// 2^68 squared
	localparam int SCL_SH = 136;

	localparam logic [MU_W-1:0] MU_RESET = 64'd26122675441;

	localparam logic [ACC_W-1:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;
	localparam logic [ROOT_W-1:0] LIM_POS = 65'h0_7FFF_FFFF_FFFF_FFFF;
	localparam logic [ROOT_W-1:0] LIM_NEG = 65'h0_8000_0000_0000_0000;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [ERR_W-1:0] err_x;
		logic signed [ERR_W-1:0] err_y;
		logic signed [ERR_W-1:0] err_z;
	} ggc_in_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc_x;
		logic signed [ACC_W-1:0] acc_y;
		logic signed [ACC_W-1:0] acc_z;
		logic saturated;
		logic zero_radius;
	} ggc_out_t;

endpackage

// File: rtl/ggc_dly.sv
// Delay line with enable for side-band bits that travel beside the datapath.
// Depends on nothing.
module ggc_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sh_q [N];

	// shift when the pipeline moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) sh_q[i] <= '0;
		end else if (en) begin
			sh_q[0] <= d;
			for (int i = 1; i < N; i++) sh_q[i] <= sh_q[i-1];
		end
	end

	assign q = sh_q[N-1];

endmodule

// File: rtl/ggc_mul.sv
// Pipelined unsigned multiplier: one 32-bit digit of b per stage, each stage
// a row of 32x32 products summed into the running product.
// Depends on nothing. WB must exceed 32.
module ggc_mul #(
	parameter int WA = 64,
	parameter int WB = 64
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic [WA+WB-1:0] p
);

	localparam int NL = (WA + 31) / 32;
	localparam int NC = (WB + 31) / 32;
	localparam int AP = 32 * NL;
	localparam int BP = 32 * NC;
	localparam int PP = AP + BP;

	logic [AP-1:0] opa_s [NC-1];
	logic [BP-1:0] opb_s [NC-1];
	logic [PP-1:0] acc_s [NC];

	for (genvar k = 0; k < NC; k++) begin : g_st
		logic [AP-1:0] a_c;
		logic [BP-1:0] b_c;
		logic [PP-1:0] acc_c;
		logic [AP+31:0] ev;
		logic [AP+31:0] od;

		if (k == 0) begin : g_first
			assign a_c = AP'(a);
			assign b_c = BP'(b);
			assign acc_c = '0;
		end else begin : g_next
			assign a_c = opa_s[k-1];
			assign b_c = opb_s[k-1];
			assign acc_c = acc_s[k-1];
		end

		// even and odd limb products do not overlap among themselves
		always_comb begin
			ev = '0;
			od = '0;
			for (int j = 0; j < NL; j++) begin
				if (j % 2 == 0) ev[32*j +: 64] = a_c[32*j +: 32] * b_c[32*k +: 32];
				else od[32*j +: 64] = a_c[32*j +: 32] * b_c[32*k +: 32];
			end
		end

		// accumulate this digit's row
		always_ff @(posedge clk) begin
			if (en) acc_s[k] <= acc_c + (PP'(ev + od) << (32 * k));
		end

		if (k < NC - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					opa_s[k] <= a_c;
					opb_s[k] <= b_c;
				end
			end
		end
	end

	assign p = acc_s[NC-1][WA+WB-1:0];

endmodule

// File: rtl/ggc_div.sv
// Pipelined restoring divider: floor((num * 2^SH) / den), one quotient bit
// per stage, with a flag when the quotient does not fit in QW bits.
// Depends on nothing.
module ggc_div #(
	parameter int NW = 358,
	parameter int DW = 400,
	parameter int SH = 136,
	parameter int QW = 129
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	localparam int RW = DW + QW + 1;

	logic [RW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW+1];
	logic          ovf_s [QW+1];
	logic [RW-1:0] x_c;

	assign x_c = RW'(num) << SH;

	// range check and load
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= x_c;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= (x_c >= (RW'(den) << QW));
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_st
		localparam int B = QW - i;
		logic [RW-1:0] sub_c;
		logic          ge_c;
		logic [QW-1:0] q_c;

		assign sub_c = RW'(den_s[i-1]) << B;
		assign ge_c = rem_s[i-1] >= sub_c;

		always_comb begin
			q_c = quo_s[i-1];
			q_c[B] = ge_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= q_c;
				ovf_s[i] <= ovf_s[i-1];
			end
		end

		if (i < QW) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge_c ? rem_s[i-1] - sub_c : rem_s[i-1];
					den_s[i] <= den_s[i-1];
				end
			end
		end
	end

	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];

endmodule

// File: rtl/ggc_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
// Depends on nothing.
module ggc_sqrt #(
	parameter int WW = 129
) (
	input  logic              clk,
	input  logic              en,
	input  logic [WW-1:0]     w,
	output logic [(WW+1)/2-1:0] root
);

	localparam int RT = (WW + 1) / 2;
	localparam int XW = 2 * RT;

	logic [XW-1:0] rem_s  [RT];
	logic [RT-1:0] root_s [RT];

	for (genvar i = 0; i < RT; i++) begin : g_st
		localparam int B = RT - 1 - i;
		logic [XW-1:0] rem_c;
		logic [RT-1:0] rt_c;
		logic [XW-1:0] trial_c;
		logic          ge_c;
		logic [RT-1:0] nrt_c;

		if (i == 0) begin : g_first
			assign rem_c = XW'(w);
			assign rt_c = '0;
		end else begin : g_next
			assign rem_c = rem_s[i-1];
			assign rt_c = root_s[i-1];
		end

		// (r + 2^b)^2 - r^2 = r * 2^(b+1) + 4^b
		assign trial_c = (XW'(rt_c) << (B + 1)) | (XW'(1) << (2 * B));
		assign ge_c = rem_c >= trial_c;

		always_comb begin
			nrt_c = rt_c;
			nrt_c[B] = ge_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge_c ? rem_c - trial_c : rem_c;
				root_s[i] <= nrt_c;
			end
		end
	end

	assign root = root_s[RT-1];

endmodule

// File: rtl/gravity_gradient_correction.sv
// Top level of the point-mass gravity gradient correction pipeline.
// Depends on ggc_pkg, ggc_dly, ggc_mul, ggc_div and ggc_sqrt.
//
//   port group      dir   handshake          payload
//   in_*            in    in_valid/in_stall   ggc_in_t  position and error
//   out_*           out   out_valid/out_stall ggc_out_t correction and flags
//   cfg_*           in    cfg_wr_en           grav_param (64 bits)
//
// One request enters per cycle while in_stall is low; its result shows on
// out_valid after the quotient divider and the 65-stage square root.
// Reset clears the valid bits and loads the default gravitational parameter.
// An out_stall holds the pipeline only while a result waits in the output
// register and another one is at the end of the pipeline; empty slots are
// squeezed out meanwhile.
module gravity_gradient_correction (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ggc_pkg::ggc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ggc_pkg::ggc_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [63:0]       cfg_wr_data
);

	localparam int PW = ggc_pkg::POS_W;
	localparam int EW = ggc_pkg::ERR_W;
	localparam int MW = ggc_pkg::MU_W;
	localparam int AW = ggc_pkg::ACC_W;
	localparam int QW = ggc_pkg::QUO_W;
	localparam int RT = ggc_pkg::ROOT_W;
	localparam int SFW = ggc_pkg::DEN_W;
	localparam int SQW = 2 * PW;
	localparam int PEW = PW + EW;
	localparam int SW = SQW + 2;
	localparam int DSW = PEW + 2;
	localparam int D3W = DSW + 1;
	localparam int NMW = D3W + PW;
	localparam int ZW = NMW + MW;
	localparam int Z2W = 2 * ZW;

	// stage numbers of the main points
	localparam int T_S3 = 1 + (PW + 31) / 32;
	localparam int T_S5 = T_S3 + 2;
	localparam int T_S7 = T_S5 + (PW + 31) / 32;
	localparam int T_NM = T_S7 + 2;
	localparam int T_Z2 = T_NM + (MW + 31) / 32 + (ZW + 31) / 32;
	localparam int T_DIV = T_Z2 + QW + 1;
	localparam int T_SQ = T_DIV + RT;
	// |r|^10 reaches the divider at T_Z2 as well
	localparam int L_S4 = (SW + 31) / 32 + (2 * SW + 31) / 32;

	typedef struct packed {
		logic [2:0][PW-1:0] pa;
		logic [2:0][EW-1:0] ea;
		logic [2:0]         ps;
		logic [2:0]         es;
	} ax_t;

	logic          adv;
	logic          vld_end;
	logic [MW-1:0] grav_param_q;
	logic          out_valid_q;
	ggc_pkg::ggc_out_t out_data_q;

	logic [2:0][PW-1:0] pin;
	logic [2:0][EW-1:0] ein;
	ax_t ax_s1;
	ax_t ax_s5;
	logic [2:0] sg_s3;

	logic [2:0][SQW-1:0] sq_s3;
	logic [2:0][PEW-1:0] pe_s3;
	logic [SW-1:0]       ssum_s4;
	logic [DSW-1:0]      dsum_s4;
	logic [DSW-1:0]      dabs_c;
	logic [SW-1:0]       ssum_s5;
	logic [D3W-1:0]      dm3_s5;
	logic                dsg_s5;
	logic                zero_s5;
	logic [5:0]          nsg_in;
	logic [5:0]          nsg_s7;

	logic [2:0][NMW-1:0]     tt_s7;
	logic [2:0][SW+PW-1:0]   uu_s7;
	logic [2:0][NMW:0]       nn_s8;
	logic [2:0][NMW-1:0]     nm_s9;
	logic [2:0]              nsg_s9;
	logic [2:0][ZW-1:0]      zz_p;
	logic [2:0][Z2W-1:0]     z2_p;
	logic [2*SW-1:0]         s2_p;
	logic [4*SW-1:0]         s4_p;
	logic [SW-1:0]           s_dly;
	logic [5*SW-1:0]         s5_p;
	logic [2:0][QW-1:0]      quo_p;
	logic [2:0]              ovf_p;
	logic [2:0]              ovf_end;
	logic [2:0][RT-1:0]      root_p;
	logic [2:0]              nsg_end;
	logic                    zero_end;

	// pipeline moves unless a held result would be overwritten
	assign adv = !vld_end || !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) grav_param_q <= ggc_pkg::MU_RESET;
		else if (cfg_wr_en) grav_param_q <= cfg_wr_data;
	end

	assign pin[0] = in_data.pos_x;
	assign pin[1] = in_data.pos_y;
	assign pin[2] = in_data.pos_z;
	assign ein[0] = in_data.err_x;
	assign ein[1] = in_data.err_y;
	assign ein[2] = in_data.err_z;

	// stage 1: sign and magnitude split
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ax_s1.ps[i] <= pin[i][PW-1];
				ax_s1.es[i] <= ein[i][EW-1];
				ax_s1.pa[i] <= pin[i][PW-1] ? ~pin[i] + 1'b1 : pin[i];
				ax_s1.ea[i] <= ein[i][EW-1] ? ~ein[i] + 1'b1 : ein[i];
			end
		end
	end

	ggc_dly #(.W(3), .N(T_S3 - 1)) u_sg_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(ax_s1.ps ^ ax_s1.es), .q(sg_s3)
	);

	ggc_dly #(.W($bits(ax_t)), .N(T_S5 - 1)) u_ax_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(ax_s1), .q(ax_s5)
	);

	// stages 2-3: squares and position-error products
	for (genvar i = 0; i < 3; i++) begin : g_m1
		ggc_mul #(.WA(PW), .WB(PW)) u_sq (
			.clk(clk), .en(adv), .a(ax_s1.pa[i]), .b(ax_s1.pa[i]), .p(sq_s3[i])
		);
		ggc_mul #(.WA(EW), .WB(PW)) u_pe (
			.clk(clk), .en(adv), .a(ax_s1.ea[i]), .b(ax_s1.pa[i]), .p(pe_s3[i])
		);
	end

	// stage 4: r.r and signed r.dr
	always_ff @(posedge clk) begin
		if (adv) begin
			ssum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
			dsum_s4 <= (sg_s3[0] ? DSW'(0) - DSW'(pe_s3[0]) : DSW'(pe_s3[0]))
				+ (sg_s3[1] ? DSW'(0) - DSW'(pe_s3[1]) : DSW'(pe_s3[1]))
				+ (sg_s3[2] ? DSW'(0) - DSW'(pe_s3[2]) : DSW'(pe_s3[2]));
		end
	end

	assign dabs_c = dsum_s4[DSW-1] ? DSW'(0) - dsum_s4 : dsum_s4;

	// stage 5: 3*|r.dr| and the zero radius check
	always_ff @(posedge clk) begin
		if (adv) begin
			ssum_s5 <= ssum_s4;
			dm3_s5 <= D3W'({dabs_c[DSW-2:0], 1'b0}) + D3W'(dabs_c[DSW-2:0]);
			dsg_s5 <= dsum_s4[DSW-1];
			zero_s5 <= (ssum_s4 == '0);
		end
	end

	// term signs: 3*D*P_i and S*E_i
	assign nsg_in = {ax_s5.ps ^ {3{dsg_s5}}, ax_s5.es};

	ggc_dly #(.W(6), .N(T_S7 - T_S5)) u_nsg_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(nsg_in), .q(nsg_s7)
	);

	// stages 6-7: both numerator terms
	for (genvar i = 0; i < 3; i++) begin : g_m2
		ggc_mul #(.WA(D3W), .WB(PW)) u_t (
			.clk(clk), .en(adv), .a(dm3_s5), .b(ax_s5.pa[i]), .p(tt_s7[i])
		);
		ggc_mul #(.WA(SW), .WB(PW)) u_u (
			.clk(clk), .en(adv), .a(ssum_s5), .b(PW'(ax_s5.ea[i])), .p(uu_s7[i])
		);
	end

	// stages 8-9: numerator, then its magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nn_s8[i] <= (nsg_s7[3+i] ? (NMW+1)'(0) - {1'b0, tt_s7[i]} : {1'b0, tt_s7[i]})
					- (nsg_s7[i] ? (NMW+1)'(0) - {1'b0, uu_s7[i][NMW-1:0]}
						: {1'b0, uu_s7[i][NMW-1:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nsg_s9[i] <= nn_s8[i][NMW];
				nm_s9[i] <= nn_s8[i][NMW] ? NMW'((NMW+1)'(0) - nn_s8[i]) : nn_s8[i][NMW-1:0];
			end
		end
	end

	// |r|^10 chain
	ggc_mul #(.WA(SW), .WB(SW)) u_s2 (
		.clk(clk), .en(adv), .a(ssum_s5), .b(ssum_s5), .p(s2_p)
	);
	ggc_mul #(.WA(2 * SW), .WB(2 * SW)) u_s4 (
		.clk(clk), .en(adv), .a(s2_p), .b(s2_p), .p(s4_p)
	);
	ggc_dly #(.W(SW), .N(L_S4)) u_s_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(ssum_s5), .q(s_dly)
	);
	ggc_mul #(.WA(4 * SW), .WB(SW)) u_s5 (
		.clk(clk), .en(adv), .a(s4_p), .b(s_dly), .p(s5_p)
	);

	// per axis: mu*|N|, its square, quotient by |r|^10, square root
	for (genvar i = 0; i < 3; i++) begin : g_ax
		ggc_mul #(.WA(NMW), .WB(MW)) u_z (
			.clk(clk), .en(adv), .a(nm_s9[i]), .b(grav_param_q), .p(zz_p[i])
		);
		ggc_mul #(.WA(ZW), .WB(ZW)) u_z2 (
			.clk(clk), .en(adv), .a(zz_p[i]), .b(zz_p[i]), .p(z2_p[i])
		);
		ggc_div #(.NW(Z2W), .DW(SFW), .SH(ggc_pkg::SCL_SH), .QW(QW)) u_div (
			.clk(clk), .en(adv), .num(z2_p[i]), .den(s5_p[SFW-1:0]),
			.quo(quo_p[i]), .ovf(ovf_p[i])
		);
		ggc_sqrt #(.WW(QW)) u_sqrt (
			.clk(clk), .en(adv), .w(quo_p[i]), .root(root_p[i])
		);
	end

	ggc_dly #(.W(3), .N(T_SQ - T_DIV)) u_ovf_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(ovf_p), .q(ovf_end)
	);
	ggc_dly #(.W(3), .N(T_SQ - T_NM)) u_sgn_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(nsg_s9), .q(nsg_end)
	);
	ggc_dly #(.W(1), .N(T_SQ - T_S5)) u_zero_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(zero_s5), .q(zero_end)
	);
	ggc_dly #(.W(1), .N(T_SQ)) u_vld_dly (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(in_valid), .q(vld_end)
	);

	// sign, saturation and zero radius override
	logic [2:0][AW-1:0] acc_c;
	logic [2:0]         sat_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat_c[i] = ovf_end[i]
				|| (root_p[i] > (nsg_end[i] ? ggc_pkg::LIM_NEG : ggc_pkg::LIM_POS));
			if (zero_end) acc_c[i] = '0;
			else if (sat_c[i]) acc_c[i] = nsg_end[i] ? ggc_pkg::ACC_MIN : ggc_pkg::ACC_MAX;
			else if (nsg_end[i]) acc_c[i] = ~root_p[i][AW-1:0] + 1'b1;
			else acc_c[i] = root_p[i][AW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (!out_valid_q || !out_stall) out_valid_q <= vld_end;
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_data_q.acc_x <= acc_c[0];
			out_data_q.acc_y <= acc_c[1];
			out_data_q.acc_z <= acc_c[2];
			out_data_q.saturated <= !zero_end && (sat_c != '0);
			out_data_q.zero_radius <= zero_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

// File: dv/ggc_checker.sv
`timescale 1ns / 1ps
// Checker for the gravity gradient correction block: watches the request,
// result and register ports, predicts each correction and compares it.
// Depends on ggc_pkg.
module ggc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  ggc_pkg::ggc_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  ggc_pkg::ggc_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [63:0]       cfg_wr_data,
	output int                errors,
	output int                pending
);

	// wide enough for |r|^10 times the square of a 64-bit root
	typedef logic signed [639:0] wide_t;

	logic [ggc_pkg::MU_W-1:0] mu_copy;
	ggc_pkg::ggc_out_t corrections_due[$];

	// exact gravity gradient applied to the error, truncated then clipped
	function automatic ggc_pkg::ggc_out_t gradient_correction(ggc_pkg::ggc_in_t d,
			logic [ggc_pkg::MU_W-1:0] mu);
		wide_t p[3];
		wide_t e[3];
		wide_t rsq, rdot, rsq5, num, scaled, scaled_sq, trial, mu_w;
		logic [63:0] mag, t;
		logic [ggc_pkg::ACC_W-1:0] acc[3];
		logic neg, sat;
		ggc_pkg::ggc_out_t res;
		p[0] = d.pos_x; p[1] = d.pos_y; p[2] = d.pos_z;
		e[0] = d.err_x; e[1] = d.err_y; e[2] = d.err_z;
		res = '0;
		rsq = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
		if (rsq == 0) begin
			res.zero_radius = 1'b1;
			return res;
		end
		rdot = p[0] * e[0] + p[1] * e[1] + p[2] * e[2];
		rsq5 = rsq * rsq * rsq * rsq * rsq;
		mu_w = {576'd0, mu};
		sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			num = 3 * rdot * p[k] - rsq * e[k];
			neg = num < 0;
			if (neg)
				num = -num;
			scaled = (num * mu_w) <<< 68;
			scaled_sq = scaled * scaled;
			mag = '0;
			// integer square root of scaled^2 / r^10 by bisection on bits
			for (int b = 63; b >= 0; b--) begin
				t = mag | (64'd1 << b);
				trial = {576'd0, t};
				if (trial * trial * rsq5 <= scaled_sq)
					mag = t;
			end
			if (!neg) begin
				if (mag > ggc_pkg::ACC_MAX) begin
					mag = ggc_pkg::ACC_MAX;
					sat = 1'b1;
				end
				acc[k] = mag;
			end else begin
				if (mag > ggc_pkg::ACC_MIN) begin
					mag = ggc_pkg::ACC_MIN;
					sat = 1'b1;
				end
				acc[k] = -mag;
			end
		end
		res.acc_x = acc[0];
		res.acc_y = acc[1];
		res.acc_z = acc[2];
		res.saturated = sat;
		return res;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	assign pending = corrections_due.size();

	// register copy, prediction on request, comparison on result
	always @(posedge clk or negedge arst_n) begin
		ggc_pkg::ggc_out_t want;
		if (!arst_n) begin
			mu_copy = ggc_pkg::MU_RESET;
			corrections_due.delete();
			errors = 0;
		end else begin
			if (cfg_wr_en)
				mu_copy = cfg_wr_data;
			if (in_valid && !in_stall)
				corrections_due.push_back(gradient_correction(in_data, mu_copy));
			if (out_valid && !out_stall) begin
				if (corrections_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, got %0h", $time, out_data);
				end else begin
					want = corrections_due.pop_front();
					check_field("acc_x", want.acc_x, out_data.acc_x);
					check_field("acc_y", want.acc_y, out_data.acc_y);
					check_field("acc_z", want.acc_z, out_data.acc_z);
					check_field("saturated", want.saturated, out_data.saturated);
					check_field("zero_radius", want.zero_radius, out_data.zero_radius);
				end
			end
		end
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the gravity gradient correction testbench: clock, reset, request
// stimulus, result stalls and the verdict. Depends on ggc_pkg, ggc_checker
// and gravity_gradient_correction.
module testbench;

	localparam int IDLE_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 260;
	localparam int HOLD_CYCLES = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ggc_pkg::ggc_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ggc_pkg::ggc_out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [63:0] cfg_wr_data = '0;
	logic long_hold = 1'b0;
	int errors, pending;
	int idle_cycles = 0;
	int burst_left = 0;

	always #6 clk = ~clk;

	gravity_gradient_correction u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	ggc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.errors(errors), .pending(pending)
	);

	// result stalls: a stall mode redrawn at random, long hold on request
	always @(posedge clk) begin
		static int cyc = 0;
		static int mode = 0;
		static int hold = 0;
		cyc++;
		if (cyc % 64 == 0)
			mode = $urandom_range(0, 2);
		if (long_hold)
			hold = HOLD_CYCLES;
		if (hold > 0) begin
			hold--;
			out_stall <= 1'b1;
		end else if (mode == 0)
			out_stall <= 1'b0;
		else if (mode == 1)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= ($urandom_range(0, 3) != 0);
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one request, return at the edge that takes it, then maybe a gap
	task automatic send_request(input ggc_pkg::ggc_in_t d);
		in_data <= d;
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mu(input logic [63:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [ggc_pkg::POS_W-1:0] rand_pos(int kind);
		logic [63:0] r;
		r = {$urandom, $urandom};
		case (kind)
			0: return r[ggc_pkg::POS_W-1:0];
			1: return $signed(r[31:0]) >>> $urandom_range(0, 28);
			2: return 0;
			default: return $signed(r[ggc_pkg::POS_W-1:0]) >>> $urandom_range(8, 30);
		endcase
	endfunction

	function automatic logic signed [ggc_pkg::ERR_W-1:0] rand_err();
		logic [31:0] r;
		r = $urandom;
		return $urandom_range(0, 1) ? r : $signed(r) >>> $urandom_range(0, 31);
	endfunction

	function automatic ggc_pkg::ggc_in_t rand_request();
		ggc_pkg::ggc_in_t d;
		int kind;
		kind = $urandom_range(0, 20) == 0 ? 2 : $urandom_range(0, 3);
		if (kind == 2)
			kind = $urandom_range(0, 3) == 0 ? 2 : 3;
		d.pos_x = rand_pos(kind);
		d.pos_y = rand_pos(kind == 2 ? 2 : $urandom_range(0, 4) == 0 ? 2 : kind);
		d.pos_z = rand_pos(kind == 2 ? 2 : $urandom_range(0, 4) == 0 ? 2 : kind);
		d.err_x = rand_err();
		d.err_y = rand_err();
		d.err_z = rand_err();
		return d;
	endfunction

	initial begin
		ggc_pkg::ggc_in_t d;
		ggc_pkg::ggc_in_t directed[$];
		logic [63:0] mus[4];
		localparam logic signed [ggc_pkg::POS_W-1:0] PMAX =
			{1'b0, {(ggc_pkg::POS_W-1){1'b1}}};
		localparam logic signed [ggc_pkg::POS_W-1:0] PMIN =
			{1'b1, {(ggc_pkg::POS_W-1){1'b0}}};
		localparam logic signed [ggc_pkg::ERR_W-1:0] EMAX =
			{1'b0, {(ggc_pkg::ERR_W-1){1'b1}}};
		localparam logic signed [ggc_pkg::ERR_W-1:0] EMIN =
			{1'b1, {(ggc_pkg::ERR_W-1){1'b0}}};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero radius, extremes, single axes, typical orbit
		directed.push_back('{0, 0, 0, 0, 0, 0});
		directed.push_back('{0, 0, 0, EMAX, EMIN, 1});
		directed.push_back('{PMAX, PMAX, PMAX, EMAX, EMAX, EMAX});
		directed.push_back('{PMIN, PMIN, PMIN, EMIN, EMIN, EMIN});
		directed.push_back('{PMAX, PMIN, PMAX, EMIN, EMAX, EMIN});
		directed.push_back('{1, 0, 0, EMAX, 0, 0});
		directed.push_back('{-1, 0, 0, EMIN, 0, 0});
		directed.push_back('{0, 1, 0, 0, EMIN, EMAX});
		directed.push_back('{0, 0, -1, EMAX, EMAX, EMIN});
		directed.push_back('{1, 1, 1, -1, -1, -1});
		directed.push_back('{458752000, 0, 0, 16777216, 0, 0});
		directed.push_back('{0, -458752000, 0, 0, 16777216, 0});
		directed.push_back('{0, 0, 458752000, 16777216, 16777216, 16777216});
		directed.push_back('{300000000, -200000000, 250000000, 12345, -67890, 424242});
		directed.push_back('{PMAX, 0, 0, 0, 0, 0});
		directed.push_back('{PMIN, 0, 0, 1, 0, 0});
		directed.push_back('{65536, 65536, 0, 0, 0, EMAX});
		directed.push_back('{-5, 3, 7, EMIN, EMAX, 0});
		foreach (directed[i])
			send_request(directed[i]);
		repeat (180)
			send_request(rand_request());
		wait_drained();

		// register settings: zero, largest, random with a long hold, one, default
		// the long hold gets enough requests to fill the pipeline
		mus[0] = '0;
		mus[1] = '1;
		mus[2] = {$urandom, $urandom};
		mus[3] = 64'd1;
		foreach (mus[i]) begin
			write_mu(mus[i]);
			if (i == 2)
				long_hold <= 1'b1;
			@(posedge clk);
			long_hold <= 1'b0;
			repeat (i == 2 ? 270 : 150)
				send_request(rand_request());
			wait_drained();
		end
		write_mu(ggc_pkg::MU_RESET);
		repeat (30)
			send_request(rand_request());
		wait_drained();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: gravity_gradient_correction.f
rtl/ggc_pkg.sv
rtl/ggc_dly.sv
rtl/ggc_mul.sv
rtl/ggc_div.sv
rtl/ggc_sqrt.sv
rtl/gravity_gradient_correction.sv
dv/ggc_checker.sv
dv/testbench.sv
